[hdl/assert_macros.svh]
// assertion macros for the checker file of the rtc calendar block
// no dependencies; a file takes this header by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is active
`define RTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rtc_cal: property failed");

// clocked property that is also checked during reset
`define RTC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rtc_cal: reset property failed");

`endif

[hdl/rtc_cal_pkg.sv]
// types, constants and calendar helper functions for the rtc calendar block
// no dependencies; used by the top level and the checker
package rtc_cal_pkg;

  // calendar limits
  localparam logic [5:0]  LAST_SEC      = 6'd59;
  localparam logic [5:0]  LAST_MIN      = 6'd59;
  localparam logic [4:0]  LAST_HOUR     = 5'd23;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;
  localparam logic [6:0]  LAST_YEAR     = 7'd99;
  localparam logic [2:0]  LAST_WEEKDAY  = 3'd6;
  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [15:0] MAX_TICKS     = 16'd32768;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_TICKS     = 3'd0;
  localparam logic [2:0] CFG_AL_SECOND = 3'd1;
  localparam logic [2:0] CFG_AL_MINUTE = 3'd2;
  localparam logic [2:0] CFG_AL_HOUR   = 3'd3;
  localparam logic [2:0] CFG_AL_DAY    = 3'd4;
  localparam logic [2:0] CFG_AL_MONTH  = 3'd5;
  localparam logic [2:0] CFG_AL_YEAR   = 3'd6;
  localparam logic [2:0] CFG_AL_MASK   = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] set_year;
    logic [3:0] set_month;
    logic [4:0] set_day;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [5:0] set_second;
    logic [3:0] clear_bits;
  } rtc_in_t;

  typedef struct packed {
    logic [6:0]  now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [2:0]  now_weekday;
    logic [31:0] epoch_seconds;
    logic        alarm_hit;
    logic        minute_passed;
    logic        hour_passed;
    logic        day_passed;
  } rtc_out_t;

  // length of a month, every fourth year leap; zero for unused month codes
  function automatic logic [4:0] month_days(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of a month, february taken as 28
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // remainder by 7 through folding, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [6:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 7'(v[8:3]) + 7'(v[2:0]);
    b = 4'(a[6:3]) + 4'(a[2:0]);
    c = 4'(b[3]) + 4'(b[2:0]);
    if (c >= 4'd7) c = c - 4'd7;
    return c[2:0];
  endfunction

endpackage

[hdl/rtc_calendar_with_alarm_top.sv]
// real-time clock calendar with masked alarm, years 2000 to 2099
// depends on rtc_cal_pkg for the beat types, codes and calendar functions
//
// usage:
//   in channel (in_valid/in_ready/in_data): one beat per command, mode tick,
//   write date and time, or clear flags. out channel (out_valid/out_ready/
//   out_data): exactly one beat per command, showing the calendar, second
//   count and sticky flags after that command.
//   cfg port: cfg_wr_en with cfg_index and cfg_wdata writes ticks per second
//   and the alarm registers; write only while no command is in flight.
//   order: an accepted command waits in the input register, is then applied
//   to the state/result register, and that register holds its result beat.
//   throughput: one command per cycle unless stalled; the whole carry chain,
//   the alarm compare and the date to second-count conversion (one 16x17
//   multiply) sit between the input register and the state/result register.
//   reset: calendar goes to Saturday 2000-01-01 00:00:00, flags and counts
//   clear, ticks per second is 1 and the alarm is off; both channels empty.
//   stall: while out_ready is low the result beat holds; one more command
//   can wait in the input register, then in_ready drops.
module rtc_calendar_with_alarm_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rtc_cal_pkg::rtc_in_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rtc_cal_pkg::rtc_out_t                out_data,
  input  logic                                 cfg_wr_en,
  input  logic [rtc_cal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtc_cal_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [15:0] ticks_r;
  logic [5:0]  al_second_r;
  logic [5:0]  al_minute_r;
  logic [4:0]  al_hour_r;
  logic [4:0]  al_day_r;
  logic [3:0]  al_month_r;
  logic [6:0]  al_year_r;
  logic [5:0]  al_mask_r;

  // input stage
  logic                 s1_valid_r;
  rtc_cal_pkg::rtc_in_t s1_item_r;
  logic                 adv;

  // calendar state, also the result register
  logic        out_valid_r, out_valid_nxt;
  logic [14:0] sub_r, sub_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [6:0]  year_r, year_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic [31:0] epoch_r, epoch_nxt;
  logic        alarm_r, alarm_nxt;
  logic [2:0]  flags_r, flags_nxt;

  // end-of-second values
  logic [5:0]  e_second, e_minute;
  logic [4:0]  e_hour, e_day;
  logic [3:0]  e_month;
  logic [6:0]  e_year;
  logic [2:0]  e_weekday;
  logic [31:0] e_epoch;
  logic [2:0]  e_flags;
  logic        e_hit;

  // tick and write decode
  logic [15:0] limit;
  logic        sec_end;
  logic        wr_ok;
  logic [7:0]  leap_days;
  logic [8:0]  doy_base;
  logic        leap_adj;
  logic [15:0] wr_days;
  logic [8:0]  wk_sum;
  logic [31:0] wr_epoch;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= 16'd1;
      al_second_r <= '0;
      al_minute_r <= '0;
      al_hour_r   <= '0;
      al_day_r    <= '0;
      al_month_r  <= '0;
      al_year_r   <= '0;
      al_mask_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rtc_cal_pkg::CFG_TICKS:     ticks_r     <= cfg_wdata;
        rtc_cal_pkg::CFG_AL_SECOND: al_second_r <= cfg_wdata[5:0];
        rtc_cal_pkg::CFG_AL_MINUTE: al_minute_r <= cfg_wdata[5:0];
        rtc_cal_pkg::CFG_AL_HOUR:   al_hour_r   <= cfg_wdata[4:0];
        rtc_cal_pkg::CFG_AL_DAY:    al_day_r    <= cfg_wdata[4:0];
        rtc_cal_pkg::CFG_AL_MONTH:  al_month_r  <= cfg_wdata[3:0];
        rtc_cal_pkg::CFG_AL_YEAR:   al_year_r   <= cfg_wdata[6:0];
        rtc_cal_pkg::CFG_AL_MASK:   al_mask_r   <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result slot frees up
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // ticks per second, zero read as one and clamped at the top
  always_comb begin
    if (ticks_r == 16'd0) begin
      limit = 16'd1;
    end else if (ticks_r > rtc_cal_pkg::MAX_TICKS) begin
      limit = rtc_cal_pkg::MAX_TICKS;
    end else begin
      limit = ticks_r;
    end
    sec_end = ({1'b0, sub_r} + 16'd1) >= limit;
  end

  // calendar carry chain for the end of a second
  always_comb begin
    e_second  = second_r + 6'd1;
    e_minute  = minute_r;
    e_hour    = hour_r;
    e_day     = day_r;
    e_month   = month_r;
    e_year    = year_r;
    e_weekday = weekday_r;
    e_epoch   = epoch_r + 32'd1;
    e_flags   = flags_r;
    if (second_r >= rtc_cal_pkg::LAST_SEC) begin
      e_second   = '0;
      e_flags[0] = 1'b1;
      e_minute   = minute_r + 6'd1;
      if (minute_r >= rtc_cal_pkg::LAST_MIN) begin
        e_minute   = '0;
        e_flags[1] = 1'b1;
        e_hour     = hour_r + 5'd1;
        if (hour_r >= rtc_cal_pkg::LAST_HOUR) begin
          e_hour     = '0;
          e_flags[2] = 1'b1;
          e_weekday  = (weekday_r >= rtc_cal_pkg::LAST_WEEKDAY) ? 3'd0 : weekday_r + 3'd1;
          e_day      = day_r + 5'd1;
          if (day_r >= rtc_cal_pkg::month_days(year_r, month_r)) begin
            e_day   = 5'd1;
            e_month = month_r + 4'd1;
            if (month_r >= rtc_cal_pkg::LAST_MONTH) begin
              e_month = 4'd1;
              e_year  = year_r + 7'd1;
              if (year_r >= rtc_cal_pkg::LAST_YEAR) begin
                e_year  = '0;
                e_epoch = '0;
              end
            end
          end
        end
      end
    end
  end

  // masked alarm compare on the advanced time
  assign e_hit = (al_mask_r != 6'd0)
              && (!al_mask_r[0] || e_second == al_second_r)
              && (!al_mask_r[1] || e_minute == al_minute_r)
              && (!al_mask_r[2] || e_hour   == al_hour_r)
              && (!al_mask_r[3] || e_day    == al_day_r)
              && (!al_mask_r[4] || e_month  == al_month_r)
              && (!al_mask_r[5] || e_year   == al_year_r);

  // write check and closed-form weekday and second count
  always_comb begin
    wr_ok = (s1_item_r.set_year <= rtc_cal_pkg::LAST_YEAR)
         && (s1_item_r.set_month != 4'd0)
         && (s1_item_r.set_month <= rtc_cal_pkg::LAST_MONTH)
         && (s1_item_r.set_day != 5'd0)
         && (s1_item_r.set_day <= rtc_cal_pkg::month_days(s1_item_r.set_year,
                                                          s1_item_r.set_month))
         && (s1_item_r.set_hour <= rtc_cal_pkg::LAST_HOUR)
         && (s1_item_r.set_minute <= rtc_cal_pkg::LAST_MIN)
         && (s1_item_r.set_second <= rtc_cal_pkg::LAST_SEC);
    leap_days = (8'(s1_item_r.set_year) + 8'd3) >> 2;
    doy_base  = rtc_cal_pkg::days_before(s1_item_r.set_month);
    leap_adj  = (s1_item_r.set_month > 4'd2) && (s1_item_r.set_year[1:0] == 2'b00);
    wr_days   = 16'(s1_item_r.set_year) * rtc_cal_pkg::DAYS_PER_YEAR + 16'(leap_days)
              + 16'(doy_base) + 16'(leap_adj) + 16'(s1_item_r.set_day) - 16'd1;
    // 365 is 1 mod 7, so the weekday needs only the small terms; 2000-01-01 was day 6
    wk_sum    = 9'd5 + 9'(s1_item_r.set_year) + 9'(leap_days) + doy_base
              + 9'(leap_adj) + 9'(s1_item_r.set_day);
    wr_epoch  = 32'(wr_days) * rtc_cal_pkg::SECS_PER_DAY
              + 32'(s1_item_r.set_hour) * rtc_cal_pkg::SECS_PER_HOUR
              + 32'(s1_item_r.set_minute) * rtc_cal_pkg::SECS_PER_MIN
              + 32'(s1_item_r.set_second);
  end

  // next state per command
  always_comb begin
    sub_nxt     = sub_r;
    second_nxt  = second_r;
    minute_nxt  = minute_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    weekday_nxt = weekday_r;
    epoch_nxt   = epoch_r;
    alarm_nxt   = alarm_r;
    flags_nxt   = flags_r;
    if (adv) begin
      case (s1_item_r.mode)
        rtc_cal_pkg::MODE_TICK: begin
          if (sec_end) begin
            sub_nxt     = '0;
            second_nxt  = e_second;
            minute_nxt  = e_minute;
            hour_nxt    = e_hour;
            day_nxt     = e_day;
            month_nxt   = e_month;
            year_nxt    = e_year;
            weekday_nxt = e_weekday;
            epoch_nxt   = e_epoch;
            flags_nxt   = e_flags;
            alarm_nxt   = alarm_r | e_hit;
          end else begin
            sub_nxt = sub_r + 15'd1;
          end
        end
        rtc_cal_pkg::MODE_WRITE: begin
          if (wr_ok) begin
            sub_nxt     = '0;
            second_nxt  = s1_item_r.set_second;
            minute_nxt  = s1_item_r.set_minute;
            hour_nxt    = s1_item_r.set_hour;
            day_nxt     = s1_item_r.set_day;
            month_nxt   = s1_item_r.set_month;
            year_nxt    = s1_item_r.set_year;
            weekday_nxt = rtc_cal_pkg::mod7(wk_sum);
            epoch_nxt   = wr_epoch;
          end
        end
        rtc_cal_pkg::MODE_CLEAR: begin
          alarm_nxt = alarm_r & ~s1_item_r.clear_bits[0];
          flags_nxt = flags_r & ~s1_item_r.clear_bits[3:1];
        end
        default: ;
      endcase
    end
  end

  // result slot: filled by each applied command, emptied when taken
  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= '0;
      second_r    <= '0;
      minute_r    <= '0;
      hour_r      <= '0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= '0;
      weekday_r   <= rtc_cal_pkg::LAST_WEEKDAY;
      epoch_r     <= '0;
      alarm_r     <= 1'b0;
      flags_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
      second_r    <= second_nxt;
      minute_r    <= minute_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      weekday_r   <= weekday_nxt;
      epoch_r     <= epoch_nxt;
      alarm_r     <= alarm_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // result beat straight from the state registers
  assign out_valid               = out_valid_r;
  assign out_data.now_year       = year_r;
  assign out_data.now_month      = month_r;
  assign out_data.now_day        = day_r;
  assign out_data.now_hour       = hour_r;
  assign out_data.now_minute     = minute_r;
  assign out_data.now_second     = second_r;
  assign out_data.now_weekday    = weekday_r;
  assign out_data.epoch_seconds  = epoch_r;
  assign out_data.alarm_hit      = alarm_r;
  assign out_data.minute_passed  = flags_r[0];
  assign out_data.hour_passed    = flags_r[1];
  assign out_data.day_passed     = flags_r[2];

endmodule

[hdl/rtc_cal_checker.sv]
// port-level checker for the rtc calendar top level, bound to it below
// depends on rtc_cal_pkg and assert_macros.svh
`include "assert_macros.svh"

module rtc_cal_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input rtc_cal_pkg::rtc_out_t out_data
);

  // no result beat right after reset
  `RTC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a stalled result beat holds
  `RTC_ASSERT(a_stall_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_data))

  // time of day in a beat is always a real time
  `RTC_ASSERT(a_time_range, clk, rst_n,
    out_valid |-> out_data.now_second <= rtc_cal_pkg::LAST_SEC
      && out_data.now_minute <= rtc_cal_pkg::LAST_MIN
      && out_data.now_hour <= rtc_cal_pkg::LAST_HOUR)

  // date in a beat is always a real date
  `RTC_ASSERT(a_date_range, clk, rst_n,
    out_valid |-> out_data.now_month != 4'd0
      && out_data.now_month <= rtc_cal_pkg::LAST_MONTH
      && out_data.now_day != 5'd0
      && out_data.now_day <= rtc_cal_pkg::month_days(out_data.now_year, out_data.now_month)
      && out_data.now_year <= rtc_cal_pkg::LAST_YEAR
      && out_data.now_weekday <= rtc_cal_pkg::LAST_WEEKDAY)

endmodule

bind rtc_calendar_with_alarm_top rtc_cal_checker u_rtc_cal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
